// ----- hw/rtl/mcw_pkg.sv -----
package mcw_pkg;

    // Channel slots named by the register map
    localparam int CH_SLOTS = 5;

    localparam int COUNT_W  = 16;
    localparam int CHAN_W   = 3;
    localparam int OP_W     = 2;
    localparam int MASK_W   = 5;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;

    // Item opcodes
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_KICK = 2'd1;
    localparam logic [OP_W-1:0] OP_ACK  = 2'd2;

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_LIMIT_CH0 = 3'd1;
    localparam logic [CFG_AW-1:0] REG_LIMIT_CH1 = 3'd2;
    localparam logic [CFG_AW-1:0] REG_LIMIT_CH2 = 3'd3;
    localparam logic [CFG_AW-1:0] REG_LIMIT_CH3 = 3'd4;
    localparam logic [CFG_AW-1:0] REG_LIMIT_CH4 = 3'd5;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd100;

    typedef struct packed {
        logic [MASK_W-1:0]                 enable_mask;
        logic [CH_SLOTS-1:0][COUNT_W-1:0]  limit;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   opcode;
        logic [CHAN_W-1:0] channel;
    } t_step;

    typedef struct packed {
        logic              error_flag;
        logic [CHAN_W-1:0] error_channel;
        logic              stop_request;
    } t_status;

endpackage

// ----- hw/rtl/mcw_cfg_regs.sv -----
module mcw_cfg_regs
    import mcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_mask <= '0;
            for (int i = 0; i < CH_SLOTS; i++) begin
                r_cfg.limit[i] <= LIMIT_RESET;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_ENABLE:    r_cfg.enable_mask <= i_cfg_data[MASK_W-1:0];
                REG_LIMIT_CH0: r_cfg.limit[0] <= i_cfg_data;
                REG_LIMIT_CH1: r_cfg.limit[1] <= i_cfg_data;
                REG_LIMIT_CH2: r_cfg.limit[2] <= i_cfg_data;
                REG_LIMIT_CH3: r_cfg.limit[3] <= i_cfg_data;
                REG_LIMIT_CH4: r_cfg.limit[4] <= i_cfg_data;
                default: begin
                    // drop writes beyond the register map
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/mcw_engine.sv -----
module mcw_engine
    import mcw_pkg::*;
#(
    parameter int TICK_STEP    = 10,
    parameter int COUNT_MAX    = 65535,
    parameter int NUM_CHANNELS = 5
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_step   i_step,
    output t_status o_status
);

    localparam logic [COUNT_W:0]   STEP_W = (COUNT_W+1)'(TICK_STEP);
    localparam logic [COUNT_W:0]   MAX_W  = (COUNT_W+1)'(COUNT_MAX);
    localparam logic [COUNT_W-1:0] MAX_C  = COUNT_W'(COUNT_MAX);

    logic [COUNT_W-1:0] r_elapsed [NUM_CHANNELS];
    logic [COUNT_W-1:0] n_elapsed [NUM_CHANNELS];
    logic [COUNT_W-1:0] sat_sum   [NUM_CHANNELS];
    logic [COUNT_W:0]   raw_sum   [NUM_CHANNELS];

    logic              r_error_prev, n_error_prev;
    logic [CHAN_W-1:0] r_error_chan, n_error_chan;
    logic              r_stop_flag,  n_stop_flag;
    logic              any_err;
    logic [CHAN_W-1:0] hi_chan;

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            raw_sum[i] = {1'b0, r_elapsed[i]} + STEP_W;
            sat_sum[i] = (raw_sum[i] > MAX_W) ? MAX_C : raw_sum[i][COUNT_W-1:0];
        end
    end

    always_comb begin
        n_elapsed    = r_elapsed;
        n_error_prev = r_error_prev;
        n_error_chan = r_error_chan;
        n_stop_flag  = r_stop_flag;
        any_err      = 1'b0;
        hi_chan      = '0;
        case (i_step.opcode)
            OP_TICK: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    n_elapsed[i] = i_cfg.enable_mask[i] ? sat_sum[i] : '0;
                    // later channels override, leaving the highest in error
                    if (n_elapsed[i] > i_cfg.limit[i]) begin
                        any_err = 1'b1;
                        hi_chan = CHAN_W'(i);
                    end
                end
                if (any_err && !r_error_prev) begin
                    n_stop_flag = 1'b1;
                end else if (!any_err && r_error_prev) begin
                    n_stop_flag = 1'b0;
                end
                n_error_prev = any_err;
                n_error_chan = hi_chan;
            end
            OP_KICK: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (i_step.channel == CHAN_W'(i)) begin
                        n_elapsed[i] = '0;
                    end
                end
            end
            OP_ACK: begin
                n_stop_flag = 1'b0;
            end
            default: begin
                // unused opcode: hold state
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_elapsed[i] <= '0;
            end
            r_error_prev <= 1'b0;
            r_error_chan <= '0;
            r_stop_flag  <= 1'b0;
        end else if (i_step.valid) begin
            r_elapsed    <= n_elapsed;
            r_error_prev <= n_error_prev;
            r_error_chan <= n_error_chan;
            r_stop_flag  <= n_stop_flag;
        end
    end

    assign o_status.error_flag    = n_error_prev;
    assign o_status.error_channel = n_error_chan;
    assign o_status.stop_request  = n_stop_flag;

`ifndef SYNTH
    a_chan_needs_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error_chan != '0) |-> r_error_prev)
        else $error("error channel set without an error");

    a_stop_needs_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_error_prev |-> !r_stop_flag)
        else $error("stop request raised with no error present");

    a_stop_on_new_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.valid && i_step.opcode == OP_TICK && !r_error_prev)
        |=> (r_stop_flag == r_error_prev))
        else $error("stop request does not follow a fresh error");
`endif

endmodule

// ----- hw/rtl/multi_channel_watchdog.sv -----
// A word accepted on s_axis is held in the input register; once the status slot is free,
// the engine processes it and its status word is registered for m_axis at that same edge.
// Throughput: one word per cycle; the input register and the status register
// form a two-stage pipeline, and only a stalled m_axis holds s_axis back.
// Reset (i_rst_n low, synchronous): counters, error state and stop request
// clear, enable mask clears, every limit returns to 100.
module multi_channel_watchdog
    import mcw_pkg::*;
#(
    parameter int TICK_STEP    = 10,
    parameter int COUNT_MAX    = 65535,
    parameter int NUM_CHANNELS = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [2:0] channel, [7:3] zero
    input  logic [OP_W-1:0]   s_axis_tuser,   // [1:0] opcode

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata    // [0] error_flag, [3:1] error_channel,
                                              // [4] stop_request, [7:5] zero
);

    t_cfg    cfg;
    t_step   step;
    t_status status;

    logic              r_in_valid;
    logic [OP_W-1:0]   r_in_op;
    logic [CHAN_W-1:0] r_in_chan;
    logic              r_out_valid;
    t_status           r_out;
    logic              advance;

    assign o_cfg_ready = 1'b1;

    mcw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // move the held word into the engine whenever the status slot frees up
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign step.valid   = advance;
    assign step.opcode  = r_in_op;
    assign step.channel = r_in_chan;

    mcw_engine #(
        .TICK_STEP    (TICK_STEP),
        .COUNT_MAX    (COUNT_MAX),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_chan <= s_axis_tdata[CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.stop_request, r_out.error_channel,
                            r_out.error_flag};

`ifndef SYNTH
    a_hold_input_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready)
        |=> (r_in_valid && $stable(r_in_op) && $stable(r_in_chan)))
        else $error("pending input word lost while output stalled");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import mcw_pkg::*;

    localparam int TICK_STEP     = 10;
    localparam int COUNT_MAX     = 65535;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 3000;

    // Opcode the block must answer without any state change
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    // Register indexes beyond the map, to be ignored
    localparam logic [CFG_AW-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SPARE7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAN_W-1:0] ch;
    } t_wd_word;

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_COIN, RX_SLOW} t_rx_mode;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_AW-1:0] i_cfg_addr    = '0;
    logic [CFG_DW-1:0] i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;
    logic [OP_W-1:0]   s_axis_tuser  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;

    // Predicted watchdog state and its register copy
    logic [MASK_W-1:0]  pred_mask = '0;
    logic [COUNT_W-1:0] pred_limit [CH_SLOTS] = '{default: LIMIT_RESET};
    logic [COUNT_W-1:0] pred_elapsed [CH_SLOTS] = '{default: '0};
    logic               pred_err_seen = 1'b0;
    logic [CHAN_W-1:0]  pred_err_chan = '0;
    logic               pred_stop = 1'b0;

    t_wd_word word_q[$];
    t_status  expected_status_q[$];
    int       mismatch_count = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       idle_cycles = 0;
    logic [7:0] rx_phase = '0;
    t_rx_mode   rx_mode = RX_OPEN;

    multi_channel_watchdog dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_word(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch);
        t_wd_word w;
        w.op = op;
        w.ch = ch;
        word_q.push_back(w);
    endtask

    // Mostly ticks and kicks so errors come and go; acks and spare opcodes mixed in
    task automatic queue_random(input int n);
        int k;
        int r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                queue_word(OP_TICK, CHAN_W'($urandom_range(0, 7)));
            else if (r < 85)
                queue_word(OP_KICK, CHAN_W'(($urandom_range(0, 7) == 0)
                                            ? $urandom_range(5, 7)
                                            : $urandom_range(0, 4)));
            else if (r < 95)
                queue_word(OP_ACK, CHAN_W'($urandom_range(0, 7)));
            else
                queue_word(OP_SPARE, CHAN_W'($urandom_range(0, 7)));
        end
    endtask

    task automatic drain_results();
        while (word_q.size() != 0 || s_axis_tvalid || expected_status_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Call right after a rising edge; leaves valid high for the caller to drop
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == REG_ENABLE)
            pred_mask = val[MASK_W-1:0];
        else if (idx >= REG_LIMIT_CH0 && idx <= REG_LIMIT_CH4)
            pred_limit[idx - REG_LIMIT_CH0] = val;
    endtask

    task automatic set_config(input logic [MASK_W-1:0] mask,
                              input logic [COUNT_W-1:0] l0, input logic [COUNT_W-1:0] l1,
                              input logic [COUNT_W-1:0] l2, input logic [COUNT_W-1:0] l3,
                              input logic [COUNT_W-1:0] l4);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_SPARE6, CFG_DW'($urandom));
        write_reg(REG_ENABLE, {{(CFG_DW-MASK_W){1'b0}}, mask});
        write_reg(REG_LIMIT_CH0, l0);
        write_reg(REG_LIMIT_CH1, l1);
        write_reg(REG_LIMIT_CH2, l2);
        write_reg(REG_LIMIT_CH3, l3);
        write_reg(REG_LIMIT_CH4, l4);
        write_reg(REG_SPARE7, CFG_DW'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Feed words in bursts; predict the status word of each accepted one
    always @(posedge i_clk) begin : feed
        logic               fire;
        logic               hit;
        logic [CHAN_W-1:0]  hit_ch;
        logic [COUNT_W:0]   sum;
        logic [CHAN_W-1:0]  ch;
        t_status            st;
        t_wd_word           w;
        int                 i;
        fire = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (fire) begin
                ch = s_axis_tdata[CHAN_W-1:0];
                case (s_axis_tuser)
                    OP_TICK: begin
                        hit    = 1'b0;
                        hit_ch = '0;
                        for (i = 0; i < CH_SLOTS; i++) begin
                            if (pred_mask[i]) begin
                                sum = {1'b0, pred_elapsed[i]} + (COUNT_W+1)'(TICK_STEP);
                                pred_elapsed[i] = (sum > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                                    : sum[COUNT_W-1:0];
                            end else begin
                                pred_elapsed[i] = '0;
                            end
                            if (pred_elapsed[i] > pred_limit[i]) begin
                                hit    = 1'b1;
                                hit_ch = CHAN_W'(i);
                            end
                        end
                        // stop request follows the edges of the error state
                        if (hit && !pred_err_seen)
                            pred_stop = 1'b1;
                        else if (!hit && pred_err_seen)
                            pred_stop = 1'b0;
                        pred_err_seen = hit;
                        pred_err_chan = hit_ch;
                    end
                    OP_KICK: begin
                        if (ch < CH_SLOTS)
                            pred_elapsed[ch] = '0;
                    end
                    OP_ACK: pred_stop = 1'b0;
                    default: ;
                endcase
                st.error_flag    = pred_err_seen;
                st.error_channel = pred_err_chan;
                st.stop_request  = pred_stop;
                expected_status_q.push_back(st);
            end
            if (!s_axis_tvalid || fire) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (word_q.size() != 0) begin
                    w = word_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= w.op;
                    s_axis_tdata  <= {{(8-CHAN_W){1'b0}}, w.ch};
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver stalls: mode switches each time the 8-bit phase counter wraps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_phase <= rx_phase + 8'd1;
            if (rx_phase == 8'hFF)
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_MOSTLY: m_axis_tready <= (rx_phase[1:0] != 2'b11);
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                default:   m_axis_tready <= (rx_phase[3:0] < 4'd4);
            endcase
        end
    end

    always @(posedge i_clk) begin : check
        t_status want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_status_q.size() == 0) begin
                report_mismatch($sformatf("status word 0x%02h with nothing expected",
                                          m_axis_tdata));
            end else begin
                want = expected_status_q.pop_front();
                if (m_axis_tdata[0] !== want.error_flag)
                    report_mismatch($sformatf("error_flag got %b want %b",
                                              m_axis_tdata[0], want.error_flag));
                if (m_axis_tdata[3:1] !== want.error_channel)
                    report_mismatch($sformatf("error_channel got %0d want %0d",
                                              m_axis_tdata[3:1], want.error_channel));
                if (m_axis_tdata[4] !== want.stop_request)
                    report_mismatch($sformatf("stop_request got %b want %b",
                                              m_axis_tdata[4], want.stop_request));
                if (m_axis_tdata[7:5] !== 3'b000)
                    report_mismatch($sformatf("pad bits got %b", m_axis_tdata[7:5]));
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int p;
        int k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: nothing enabled, spare opcode, ack, stray kicks, tick
        queue_word(OP_SPARE, 3'd5);
        queue_word(OP_ACK, 3'd2);
        queue_word(OP_KICK, 3'd0);
        queue_word(OP_KICK, 3'd7);
        queue_word(OP_TICK, 3'd7);

        // channels 0 and 4 trip at once, highest one reported
        set_config(5'h1F, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        queue_word(OP_TICK, 3'd0);
        queue_word(OP_KICK, 3'd4);
        queue_word(OP_KICK, 3'd0);
        queue_word(OP_KICK, 3'd5);
        queue_word(OP_KICK, 3'd6);
        queue_word(OP_ACK, 3'd0);
        queue_word(OP_TICK, 3'd3);
        queue_word(OP_SPARE, 3'd2);
        queue_word(OP_TICK, 3'd0);

        // errors clear, then return and raise the stop request again
        set_config(5'b01110, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(OP_TICK, 3'd1);
        queue_word(OP_ACK, 3'd7);
        set_config(5'h1F, 16'd0, 16'd0, 16'd5, 16'hFFFF, 16'hFFFF);
        queue_word(OP_TICK, 3'd4);
        queue_word(OP_KICK, 3'd2);
        queue_word(OP_ACK, 3'd1);
        queue_word(OP_TICK, 3'd6);

        for (p = 0; p < 8; p++) begin
            case (p)
                0: set_config(5'h1F, COUNT_W'($urandom_range(0, 150)),
                              COUNT_W'($urandom_range(0, 150)),
                              COUNT_W'($urandom_range(0, 150)),
                              COUNT_W'($urandom_range(0, 150)),
                              COUNT_W'($urandom_range(0, 150)));
                2: set_config('0, '0, '0, '0, '0, '0);
                3: set_config(5'h1F, '0, '0, '0, '0, '0);
                4: set_config(5'h1F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: set_config(MASK_W'($urandom_range(0, 31)),
                                    COUNT_W'($urandom_range(20, 160)),
                                    COUNT_W'($urandom_range(20, 160)),
                                    COUNT_W'($urandom_range(20, 160)),
                                    COUNT_W'($urandom_range(20, 160)),
                                    COUNT_W'($urandom_range(20, 160)));
            endcase
            queue_random(45);
            // hold off until every status word is back
            drain_results();
            queue_random(45);
        end

        // run one counter up under a high limit, then kick it
        set_config(5'b00100, 16'd100, 16'd100, 16'hFFFE, 16'd100, 16'd100);
        for (k = 0; k < 30; k++) begin
            if (k % 9 == 4)
                queue_word(OP_ACK, CHAN_W'($urandom_range(0, 7)));
            else if (k % 13 == 6)
                queue_word(OP_SPARE, CHAN_W'($urandom_range(0, 7)));
            else
                queue_word(OP_TICK, CHAN_W'($urandom_range(0, 7)));
        end
        queue_word(OP_KICK, 3'd2);
        queue_word(OP_TICK, 3'd0);
        queue_word(OP_TICK, 3'd0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
